// ===== rtl/core/median_filter_5x5_defines.svh =====
// Assertion macros shared by the median filter RTL files.
`ifndef MEDIAN_FILTER_5X5_DEFINES_SVH
`define MEDIAN_FILTER_5X5_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define MF5_ASSERT_NOW(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define MF5_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/core/mf5_pkg.sv =====
// Shared constants and types of the 5x5 median filter.
package mf5_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int PIX_W        = 8;
    localparam int DIM_W        = 12;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(HEIGHT_LIMIT);
    localparam int EFFW_W       = $clog2(MAX_WIDTH + 1);
    localparam int EFFH_W       = $clog2(HEIGHT_LIMIT + 1);

    // Each line store word holds one column of the four previous rows.
    localparam int ROWS        = 4;
    localparam int SLOT_W      = $clog2(ROWS);
    localparam int WORD_W      = ROWS * PIX_W;
    localparam int WIN         = ROWS + 1;
    localparam int TAPS        = WIN * WIN;
    localparam int MEDIAN_RANK = 12;
    localparam int EDGE        = 2;
    localparam int RANK_W      = $clog2(TAPS);
    localparam int MED_LAT     = 3;

    // Word slot that holds the centre pixel when it passes through.
    localparam logic [SLOT_W-1:0] SLOT_PASS   = SLOT_W'(EDGE);
    localparam logic [SLOT_W-1:0] SLOT_NARROW = SLOT_W'(ROWS - 1);

    // Queue depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef enum logic {
        FUNC_PIXEL = 1'b0,
        FUNC_FLUSH = 1'b1
    } t_func;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [ROWS-1:0][PIX_W-1:0] t_word;
    typedef logic [TAPS-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic              is_pixel;
        logic              has_out;
        logic              inner;
        logic              last;
        t_pix              px;
        logic [COL_W-1:0]  col;
        logic [COL_W-1:0]  paddr;
        logic [SLOT_W-1:0] slot;
    } t_job;

    typedef struct packed {
        logic inner;
        logic last;
        t_pix pass_pix;
    } t_ctl;

endpackage

// ===== rtl/core/mf5_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module mf5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata0 <= r_mem[i_raddr0];
            o_rdata1 <= r_mem[i_raddr1];
        end
    end

endmodule

// ===== rtl/core/mf5_front.sv =====
// Front end: configuration registers, raster counters and word classification.
`include "median_filter_5x5_defines.svh"

module mf5_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mf5_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mf5_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [mf5_pkg::PIX_W-1:0]     i_pixel_in,
    input  logic                          i_q_full,
    output logic                          o_q_push,
    output mf5_pkg::t_job                 o_q_job
);

    logic [mf5_pkg::DIM_W-1:0]  r_width;
    logic [mf5_pkg::DIM_W-1:0]  r_height;
    logic [mf5_pkg::EFFW_W-1:0] w_eff;
    logic [mf5_pkg::EFFH_W-1:0] h_eff;
    logic [mf5_pkg::COL_W-1:0]  r_in_col, n_in_col;
    logic [mf5_pkg::ROW_W-1:0]  r_in_row, n_in_row;
    logic [mf5_pkg::COL_W-1:0]  r_out_col, n_out_col;
    logic [mf5_pkg::ROW_W-1:0]  r_out_row, n_out_row;
    logic                       r_tail, n_tail;
    logic cfg_acc, in_acc, is_flush, width_one;
    logic in_col_end, in_row_end, out_col_end, out_row_end;
    logic out_now, inner, take_pixel, take_flush;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign is_flush    = (mf5_pkg::t_func'(i_func) == mf5_pkg::FUNC_FLUSH);

    // Out-of-range sizes are clamped to the nearest legal value.
    always_comb begin
        if (r_width == '0) begin
            w_eff = mf5_pkg::EFFW_W'(1);
        end else if (32'(r_width) > mf5_pkg::MAX_WIDTH) begin
            w_eff = mf5_pkg::EFFW_W'(mf5_pkg::MAX_WIDTH);
        end else begin
            w_eff = mf5_pkg::EFFW_W'(r_width);
        end
        if (r_height == '0) begin
            h_eff = mf5_pkg::EFFH_W'(1);
        end else if (32'(r_height) > mf5_pkg::HEIGHT_LIMIT) begin
            h_eff = mf5_pkg::EFFH_W'(mf5_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = mf5_pkg::EFFH_W'(r_height);
        end
    end

    assign width_one   = (w_eff == mf5_pkg::EFFW_W'(1));
    assign in_col_end  = (32'(r_in_col) + 1 >= 32'(w_eff));
    assign in_row_end  = (32'(r_in_row) + 1 >= 32'(h_eff));
    assign out_col_end = (32'(r_out_col) + 1 >= 32'(w_eff));
    assign out_row_end = (32'(r_out_row) + 1 >= 32'(h_eff));

    // A result is due once the input is 2*width+2 pixels ahead of the output.
    assign out_now = width_one ? (32'(r_in_row) >= 2 * mf5_pkg::EDGE)
                   : ((32'(r_in_row) > mf5_pkg::EDGE)
                      || ((32'(r_in_row) == mf5_pkg::EDGE)
                          && (32'(r_in_col) >= mf5_pkg::EDGE)));

    assign inner = (32'(r_out_row) >= mf5_pkg::EDGE)
                && (32'(r_out_row) + mf5_pkg::EDGE < 32'(h_eff))
                && (32'(r_out_col) >= mf5_pkg::EDGE)
                && (32'(r_out_col) + mf5_pkg::EDGE < 32'(w_eff));

    // Pixels during a pending tail and flushes without one are dropped here.
    assign take_pixel = in_acc && !is_flush && !r_tail;
    assign take_flush = in_acc && is_flush && r_tail;
    assign o_q_push   = take_pixel || take_flush;

    always_comb begin
        o_q_job.is_pixel = !is_flush;
        o_q_job.has_out  = is_flush || out_now;
        o_q_job.inner    = !is_flush && inner;
        o_q_job.last     = is_flush && out_col_end && out_row_end;
        o_q_job.px       = i_pixel_in;
        o_q_job.col      = r_in_col;
        o_q_job.paddr    = r_out_col;
        if (is_flush) begin
            o_q_job.slot = mf5_pkg::SLOT_W'(32'(h_eff) - 32'(r_out_row) - 1);
        end else if (width_one) begin
            o_q_job.slot = mf5_pkg::SLOT_NARROW;
        end else begin
            o_q_job.slot = mf5_pkg::SLOT_PASS;
        end
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_tail    = r_tail;
        if (cfg_acc) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_tail    = 1'b0;
        end else if (take_pixel) begin
            if (in_col_end) begin
                n_in_col = '0;
                if (in_row_end) begin
                    n_in_row = '0;
                    n_tail   = 1'b1;
                end else begin
                    n_in_row = r_in_row + 1'b1;
                end
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            if (out_now) begin
                if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + 1'b1;
                end else begin
                    n_out_col = r_out_col + 1'b1;
                end
            end
        end else if (take_flush) begin
            if (out_col_end && out_row_end) begin
                n_out_col = '0;
                n_out_row = '0;
                n_tail    = 1'b0;
            end else if (out_col_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= mf5_pkg::WIDTH_RESET;
            r_height  <= mf5_pkg::HEIGHT_RESET;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_tail    <= 1'b0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    mf5_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    mf5_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_tail    <= n_tail;
        end
    end

    `MF5_ASSERT_NOW(a_tail_input_parked, i_clk, i_rst_n, r_tail, (r_in_col == '0) && (r_in_row == '0), "input counters must rest at zero while the tail is pending")
    `MF5_ASSERT_NOW(a_out_row_in_frame, i_clk, i_rst_n, 1'b1, 32'(r_out_row) < 32'(h_eff), "output row ran past the frame")

endmodule

// ===== rtl/core/mf5_queue.sv =====
// Short job queue between the front end and the filter back end.
`include "median_filter_5x5_defines.svh"

module mf5_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mf5_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mf5_pkg::t_job o_head
);

    mf5_pkg::t_job               r_mem [mf5_pkg::QUEUE_DEPTH];
    logic [mf5_pkg::QPTR_W-1:0]  r_wp;
    logic [mf5_pkg::QPTR_W-1:0]  r_rp;
    logic [mf5_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == mf5_pkg::QCNT_W'(mf5_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + mf5_pkg::QCNT_W'(i_push) - mf5_pkg::QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    `MF5_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, i_pop, !o_empty, "job queue popped while empty")

endmodule

// ===== rtl/core/mf5_median.sv =====
// Pipelined rank-select median of the 25-pixel window.
module mf5_median (
    input  logic          i_clk,
    input  logic          i_en,
    input  mf5_pkg::t_win i_win,
    output mf5_pkg::t_pix o_median
);

    localparam int PART_W = $clog2(mf5_pkg::WIN + 1);

    logic [mf5_pkg::TAPS-1:0][mf5_pkg::TAPS-1:0] below, r_below;
    logic [mf5_pkg::TAPS-1:0][mf5_pkg::WIN-1:0][PART_W-1:0] part, r_part;
    logic [mf5_pkg::TAPS-1:0][mf5_pkg::RANK_W-1:0] rank;
    logic [mf5_pkg::TAPS-1:0] pick, r_pick;
    mf5_pkg::t_win r_vals_a, r_vals_b, r_vals_c;

    // Ties are broken by position, so every tap gets a distinct rank.
    always_comb begin
        for (int i = 0; i < mf5_pkg::TAPS; i++) begin
            for (int j = 0; j < mf5_pkg::TAPS; j++) begin
                if (j == i) begin
                    below[i][j] = 1'b0;
                end else if (j < i) begin
                    below[i][j] = (i_win[j] <= i_win[i]);
                end else begin
                    below[i][j] = (i_win[j] < i_win[i]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < mf5_pkg::TAPS; i++) begin
            for (int g = 0; g < mf5_pkg::WIN; g++) begin
                part[i][g] = '0;
                for (int t = 0; t < mf5_pkg::WIN; t++) begin
                    part[i][g] = part[i][g] + PART_W'(r_below[i][g * mf5_pkg::WIN + t]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < mf5_pkg::TAPS; i++) begin
            rank[i] = '0;
            for (int g = 0; g < mf5_pkg::WIN; g++) begin
                rank[i] = rank[i] + mf5_pkg::RANK_W'(r_part[i][g]);
            end
            pick[i] = (rank[i] == mf5_pkg::RANK_W'(mf5_pkg::MEDIAN_RANK));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_below  <= below;
            r_vals_a <= i_win;
            r_part   <= part;
            r_vals_b <= r_vals_a;
            r_pick   <= pick;
            r_vals_c <= r_vals_b;
        end
    end

    always_comb begin
        o_median = '0;
        for (int i = 0; i < mf5_pkg::TAPS; i++) begin
            o_median = o_median | (r_vals_c[i] & {mf5_pkg::PIX_W{r_pick[i]}});
        end
    end

endmodule

// ===== rtl/core/mf5_back.sv =====
// Back end: line store, 5x5 window, median pipeline and output register.
`include "median_filter_5x5_defines.svh"

module mf5_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_empty,
    input  mf5_pkg::t_job             i_q_head,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [mf5_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_last_of_frame
);

    localparam int CTL_N = mf5_pkg::MED_LAT + 1;

    logic                         adv, wr_en, s1_out;
    logic                         r_s1_v;
    mf5_pkg::t_job                r_s1;
    logic [mf5_pkg::WORD_W-1:0]   rd_col, rd_pass;
    mf5_pkg::t_word               col_word, pass_word, wr_word;
    logic                         r_lw_v;
    logic [mf5_pkg::COL_W-1:0]    r_lw_addr;
    mf5_pkg::t_word               r_lw_data;
    mf5_pkg::t_win                r_window, n_window;
    mf5_pkg::t_ctl                s1_ctl;
    logic [CTL_N-1:0]             r_cv;
    mf5_pkg::t_ctl                r_cp [CTL_N];
    mf5_pkg::t_pix                med;
    logic                         r_ov;
    mf5_pkg::t_pix                r_out_pix;
    logic                         r_out_last;

    // The whole back end moves as one when the output register can load.
    assign adv     = !r_ov || i_out_ready;
    assign o_q_pop = adv && !i_q_empty;
    assign wr_en   = adv && r_s1_v && r_s1.is_pixel;
    assign s1_out  = r_s1_v && r_s1.has_out;

    mf5_ram #(
        .WIDTH (mf5_pkg::WORD_W),
        .DEPTH (mf5_pkg::MAX_WIDTH)
    ) u_rows (
        .i_clk    (i_clk),
        .i_we     (wr_en),
        .i_waddr  (r_s1.col),
        .i_wdata  (wr_word),
        .i_re     (o_q_pop),
        .i_raddr0 (i_q_head.col),
        .i_raddr1 (i_q_head.paddr),
        .o_rdata0 (rd_col),
        .o_rdata1 (rd_pass)
    );

    // A write in the same cycle as the read is not seen by the RAM; forward it.
    assign col_word  = (r_lw_v && (r_lw_addr == r_s1.col)) ? r_lw_data
                     : mf5_pkg::t_word'(rd_col);
    assign pass_word = (r_lw_v && (r_lw_addr == r_s1.paddr)) ? r_lw_data
                     : mf5_pkg::t_word'(rd_pass);

    always_comb begin
        wr_word[0] = r_s1.px;
        for (int k = 1; k < mf5_pkg::ROWS; k++) begin
            wr_word[k] = col_word[k - 1];
        end
    end

    always_comb begin
        for (int i = 0; i < mf5_pkg::WIN; i++) begin
            for (int j = 0; j < mf5_pkg::WIN - 1; j++) begin
                n_window[i * mf5_pkg::WIN + j] = r_window[i * mf5_pkg::WIN + j + 1];
            end
        end
        for (int i = 0; i < mf5_pkg::ROWS; i++) begin
            n_window[i * mf5_pkg::WIN + mf5_pkg::WIN - 1] = col_word[mf5_pkg::ROWS - 1 - i];
        end
        n_window[mf5_pkg::ROWS * mf5_pkg::WIN + mf5_pkg::WIN - 1] = r_s1.px;
    end

    always_comb begin
        s1_ctl.inner    = r_s1.inner;
        s1_ctl.last     = r_s1.last;
        s1_ctl.pass_pix = pass_word[r_s1.slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_lw_v <= 1'b0;
            r_cv   <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_v <= o_q_pop;
                r_cv   <= {r_cv[CTL_N-2:0], s1_out};
                r_ov   <= r_cv[CTL_N-1];
            end
            if (wr_en) begin
                r_lw_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1    <= i_q_head;
            r_cp[0] <= s1_ctl;
            for (int k = 1; k < CTL_N; k++) begin
                r_cp[k] <= r_cp[k - 1];
            end
            if (r_cv[CTL_N-1]) begin
                r_out_pix  <= r_cp[CTL_N-1].inner ? med : r_cp[CTL_N-1].pass_pix;
                r_out_last <= r_cp[CTL_N-1].last;
            end
        end
        if (wr_en) begin
            r_lw_addr <= r_s1.col;
            r_lw_data <= wr_word;
            r_window  <= n_window;
        end
    end

    mf5_median u_median (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_win    (r_window),
        .o_median (med)
    );

    assign o_out_valid     = r_ov;
    assign o_pixel_out     = r_out_pix;
    assign o_last_of_frame = r_out_last;

    `MF5_ASSERT_NEXT(a_result_loads, i_clk, i_rst_n, adv && r_cv[CTL_N-1], r_ov, "finished result was not loaded into the output register")

endmodule

// ===== rtl/core/median_filter_5x5.sv =====
// Top level of the streaming 5x5 median filter.
// The block filters one 8-bit grey frame given in raster order and sustains one
// word per clock on both sides unless the output stalls: every pixel reads and
// rewrites a single word of the line store, which holds the four previous rows
// of its column, and that one read-modify-write per clock sets the rate.
// An accepted word passes through the job queue, the line store read, the
// window, three median stages and the output register. Results follow
// the stream 2*width+2 pixels behind; pixels within two of any edge pass
// through unchanged, all others become the 13th smallest of their 5x5
// neighbourhood. After a frame's last pixel, one flush word per remaining
// result draws out the tail, and the final result carries last_of_frame.
// Pixels sent while the tail is pending, and flushes with no tail, are
// accepted and dropped. Writing width or height restarts the frame and must
// only happen while the block is idle. The line store is not cleared after
// reset: no result ever uses a word that has not been written in the frame.
module median_filter_5x5 (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mf5_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mf5_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_func,
    input  logic [mf5_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [mf5_pkg::PIX_W-1:0]     o_pixel_out,
    output logic                          o_last_of_frame
);

    // Jobs travel from the front end to the back end through a short queue,
    // so an output stall only stops input once the queue has filled.
    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    mf5_pkg::t_job q_in_job;
    mf5_pkg::t_job q_head;

    mf5_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_pixel_in  (i_pixel_in),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_job     (q_in_job)
    );

    mf5_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The back end owns the line store, the window and the median pipeline.
    mf5_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_head        (q_head),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_out     (o_pixel_out),
        .o_last_of_frame (o_last_of_frame)
    );

endmodule
